// ===== rtl/assert_macros.svh =====
// shared assertion macros for the decoder checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, ignored while reset is held
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed in %m");

// property checked on every rising edge, reset included
`define ASSERT_CLK_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed in %m");

`endif

// ===== rtl/lspd_pkg.sv =====
`default_nettype none

package lspd_pkg;

    localparam int NUM_CH       = 8;
    localparam int CH_W         = 3;
    localparam int SAMPLE_W     = 8;
    localparam int THR_W        = 10;
    localparam int POS_W        = 5;
    localparam int PAT_W        = 6;
    localparam int HITS_W       = 8;
    localparam int COUNT_W      = 3;
    localparam int CFG_IDX_W    = 4;
    localparam int NUM_PATTERNS = 19;

    localparam logic [CH_W-1:0]  LAST_CH        = 3'd7;
    localparam logic [CH_W-1:0]  FIRST_LINE_CH  = 3'd2;
    localparam logic [POS_W-1:0] NO_POSITION    = 5'd31;
    localparam logic [POS_W-1:0] NO_MATCH       = 5'd0;
    localparam logic [POS_W-1:0] CROSS_POS_LO   = 5'd13;
    localparam logic [POS_W-1:0] CROSS_POS_HI   = 5'd17;
    localparam logic [COUNT_W-1:0] CROSS_HITS   = 3'd3;

    // register indexes of the threshold bank
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_CH0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_END = 4'd8;

    localparam logic [THR_W-1:0] THRESHOLD_RESET [NUM_CH] = '{
        10'd700, 10'd700, 10'd250, 10'd275, 10'd350, 10'd150, 10'd350, 10'd325
    };

    localparam logic [PAT_W-1:0] PATTERN_TABLE [NUM_PATTERNS] = '{
        6'h20, 6'h30, 6'h10, 6'h18, 6'h08, 6'h0C, 6'h04, 6'h06, 6'h02, 6'h03,
        6'h01, 6'h38, 6'h3C, 6'h3E, 6'h3F, 6'h1F, 6'h0F, 6'h07, 6'h00
    };

    typedef struct packed {
        logic [POS_W-1:0] position_code;
        logic             gap_hit;
        logic             intersection;
        logic [PAT_W-1:0] line_pattern;
    } t_result;

    // position code for a line pattern, NO_MATCH when not in the table
    function automatic logic [POS_W-1:0] f_lookup(input logic [PAT_W-1:0] pat);
        logic [POS_W-1:0] code;
        code = NO_MATCH;
        for (int k = 0; k < NUM_PATTERNS; k++) begin
            if (PATTERN_TABLE[k] == pat) begin
                code = POS_W'(k + 1);
            end
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lspd_ifs.sv =====
`default_nettype none

interface lspd_in_if
    import lspd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface lspd_out_if
    import lspd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] position_code;
    logic             gap_hit;
    logic             intersection;
    logic [PAT_W-1:0] line_pattern;

    modport source (output valid, output position_code, output gap_hit,
                    output intersection, output line_pattern, input ready);
    modport sink (input valid, input position_code, input gap_hit,
                  input intersection, input line_pattern, output ready);
endinterface

interface lspd_cfg_if
    import lspd_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [THR_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/lspd_thr_regs.sv =====
`default_nettype none

module lspd_thr_regs
    import lspd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    lspd_cfg_if.sink               i_cfg,
    input  wire logic [CH_W-1:0]   i_chan,
    output logic      [THR_W-1:0]  o_threshold
);

    logic [THR_W-1:0] r_thr [NUM_CH];
    logic             cfg_hit;

    assign i_cfg.ready = 1'b1;
    assign cfg_hit     = (i_cfg.index >= REG_THRESHOLD_CH0)
                      && (i_cfg.index < REG_THRESHOLD_END);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CH; k++) begin
                r_thr[k] <= THRESHOLD_RESET[k];
            end
        end else if (i_cfg.valid && cfg_hit) begin
            r_thr[i_cfg.index[CH_W-1:0]] <= i_cfg.data;
        end
    end

    assign o_threshold = r_thr[i_chan];

endmodule

`default_nettype wire

// ===== rtl/lspd_scan.sv =====
`default_nettype none

module lspd_scan
    import lspd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_take,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire logic [THR_W-1:0]    i_threshold,
    output logic      [CH_W-1:0]     o_chan,
    output logic                     o_emit,
    output t_result                  o_result
);

    logic [CH_W-1:0]    r_chan;
    logic [HITS_W-1:0]  r_hits;
    logic [COUNT_W-1:0] r_count;
    logic [POS_W-1:0]   r_last_pos;

    logic               hit;
    logic [HITS_W-1:0]  n_hits;
    logic [COUNT_W-1:0] n_count;
    logic [POS_W-1:0]   code;
    logic [POS_W-1:0]   n_last_pos;

    always_comb begin
        // four times the sample fits in the threshold width
        hit     = {i_sample, 2'b00} > i_threshold;
        n_hits  = r_hits;
        n_count = r_count;
        if (hit) begin
            n_hits = r_hits | (HITS_W'(8'h80) >> r_chan);
            if (r_chan >= FIRST_LINE_CH) begin
                n_count = r_count + COUNT_W'(1);
            end
        end
        code       = f_lookup(n_hits[PAT_W-1:0]);
        n_last_pos = (code != NO_MATCH) ? code : r_last_pos;
    end

    assign o_chan = r_chan;
    assign o_emit = (r_chan == LAST_CH);

    always_comb begin
        o_result.position_code = n_last_pos;
        o_result.gap_hit       = n_hits[HITS_W-1];
        o_result.line_pattern  = n_hits[PAT_W-1:0];
        o_result.intersection  = (n_count > CROSS_HITS)
                              || ((n_last_pos >= CROSS_POS_LO)
                                  && (n_last_pos <= CROSS_POS_HI));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan     <= '0;
            r_hits     <= '0;
            r_count    <= '0;
            r_last_pos <= NO_POSITION;
        end else if (i_take) begin
            if (o_emit) begin
                r_chan     <= '0;
                r_hits     <= '0;
                r_count    <= '0;
                r_last_pos <= n_last_pos;
            end else begin
                r_chan  <= r_chan + CH_W'(1);
                r_hits  <= n_hits;
                r_count <= n_count;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/line_sensor_position_decoder.sv =====
// channel        dir  payload                                           transfer
// i_sample_ch    in   sample                                            valid & ready
// o_result       out  position_code, gap_hit, intersection,
//                     line_pattern                                      valid & ready
// i_cfg          in   index, data (threshold_ch0..7 at index 0..7)      valid & ready
//
// one sample per cycle, save when a held result stalls a channel 7 sample; a sample
// goes through the input register and the compare/table decode, then the result register
// a result comes out only with the channel 7 sample, one scan per eight samples
// i_rst_n is synchronous, active low; thresholds return to their reset values
// a held result stalls a channel 7 sample in the input register only
`default_nettype none

module line_sensor_position_decoder
    import lspd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lspd_in_if.sink     i_sample_ch,
    lspd_out_if.source  o_result,
    lspd_cfg_if.sink    i_cfg
);

    logic                r_s1_valid;
    logic [SAMPLE_W-1:0] r_s1_sample;
    logic                r_out_valid;
    t_result             r_out;

    logic                s1_take;
    logic                in_ready;
    logic                emit;
    logic [CH_W-1:0]     chan;
    logic [THR_W-1:0]    threshold;
    t_result             result;

    lspd_thr_regs u_thr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_chan      (chan),
        .o_threshold (threshold)
    );

    lspd_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (s1_take),
        .i_sample    (r_s1_sample),
        .i_threshold (threshold),
        .o_chan      (chan),
        .o_emit      (emit),
        .o_result    (result)
    );

    // only a scan-closing sample needs room in the result register
    assign s1_take  = r_s1_valid && (!emit || !r_out_valid || o_result.ready);
    assign in_ready = !r_s1_valid || s1_take;
    assign i_sample_ch.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_ready) begin
            r_s1_valid <= i_sample_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_sample_ch.valid) begin
            r_s1_sample <= i_sample_ch.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_take && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_take && emit) begin
            r_out <= result;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.position_code = r_out.position_code;
    assign o_result.gap_hit       = r_out.gap_hit;
    assign o_result.intersection  = r_out.intersection;
    assign o_result.line_pattern  = r_out.line_pattern;

endmodule

`default_nettype wire

// ===== rtl/lspd_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module lspd_checker
    import lspd_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire logic [POS_W-1:0] i_position_code,
    input wire logic             i_intersection,
    input wire logic [PAT_W-1:0] i_line_pattern
);

    `ASSERT_CLK_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n |=> !i_out_valid)
    `ASSERT_CLK(a_out_held, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)
    `ASSERT_CLK(a_code_range, i_clk, i_rst_n, i_out_valid |-> (i_position_code == NO_POSITION) || ((i_position_code >= 5'd1) && (i_position_code <= 5'd19)))
    `ASSERT_CLK(a_cross_code, i_clk, i_rst_n, i_out_valid && (i_position_code >= CROSS_POS_LO) && (i_position_code <= CROSS_POS_HI) |-> i_intersection)
    `ASSERT_CLK(a_cross_hits, i_clk, i_rst_n, i_out_valid && ($countones(i_line_pattern) > 3) |-> i_intersection)

endmodule

bind line_sensor_position_decoder lspd_checker u_lspd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_position_code (o_result.position_code),
    .i_intersection  (o_result.intersection),
    .i_line_pattern  (o_result.line_pattern)
);

`default_nettype wire
